/* rtl/core/otb_pkg.sv */
// Package for the one-shot timer bank: widths, opcodes and the command record
// passed from the front end through the queue to the execution back end.
// No dependencies.
package otb_pkg;

  localparam int unsigned TIMER_COUNT_DEF = 8;
  localparam int unsigned OPCODE_W        = 2;
  localparam int unsigned IDX_W           = 3;
  localparam int unsigned TICK_W          = 32;
  localparam int unsigned LEFT_W          = 31;
  localparam int unsigned QUEUE_DEPTH     = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_POLL  = 2'd3
  } op_e;

  // Classified request as it sits in the queue.
  typedef struct packed {
    op_e               op;
    logic              hit;       // index addresses an existing timer
    logic [IDX_W-1:0]  idx;
    logic [TICK_W-1:0] duration;
  } cmd_t;

endpackage

/* rtl/core/otb_if.sv */
// Handshake channels of the timer bank: request channel and result channel.
// Depends on otb_pkg for field widths.
interface otb_req_if;
  logic                          valid;
  logic                          ready;
  logic [otb_pkg::OPCODE_W-1:0]  opcode;
  logic [otb_pkg::IDX_W-1:0]     slot_sel;
  logic [otb_pkg::TICK_W-1:0]    duration;

  modport source (output valid, output opcode, output slot_sel, output duration,
                  input ready);
  modport sink   (input valid, input opcode, input slot_sel, input duration,
                  output ready);
endinterface

interface otb_res_if;
  logic                          valid;
  logic                          ready;
  logic [otb_pkg::LEFT_W-1:0]    ticks_to_go;
  logic [otb_pkg::TICK_W-1:0]    time_running;
  logic                          elapsed;
  logic                          fired;
  logic [otb_pkg::TICK_W-1:0]    next_deadline;

  modport source (output valid, output ticks_to_go, output time_running, output elapsed,
                  output fired, output next_deadline, input ready);
  modport sink   (input valid, input ticks_to_go, input time_running, input elapsed,
                  input fired, input next_deadline, output ready);
endinterface

/* rtl/core/otb_front.sv */
// Front end of the timer bank: takes requests and classifies them into commands.
// Depends on otb_pkg and otb_if.
module otb_front #(
  parameter int unsigned TIMER_COUNT = otb_pkg::TIMER_COUNT_DEF
) (
  otb_req_if.sink        req_i,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output otb_pkg::cmd_t  push_cmd_o
);

  assign req_i.ready  = push_ready_i;
  assign push_valid_o = req_i.valid;

  always_comb begin
    push_cmd_o          = '0;
    push_cmd_o.op       = otb_pkg::op_e'(req_i.opcode);
    push_cmd_o.idx      = req_i.slot_sel;
    // out-of-range index: tick still counts, everything else is a no-op
    push_cmd_o.hit      = (32'(req_i.slot_sel) < TIMER_COUNT);
    push_cmd_o.duration = req_i.duration;
  end

endmodule

/* rtl/core/otb_queue.sv */
// Short command queue between front and back end of the timer bank.
// Depends on otb_pkg.
module otb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  otb_pkg::cmd_t  push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output otb_pkg::cmd_t  pop_cmd_o
);

  localparam int unsigned DEPTH = otb_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  otb_pkg::cmd_t      entry_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q != FULL_CNT);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* rtl/core/otb_back.sv */
// Back end of the timer bank: tick counter, timer memories, per-request update
// and the sequential walk for the earliest deadline. Depends on otb_pkg, otb_if.
module otb_back #(
  parameter int unsigned TIMER_COUNT = otb_pkg::TIMER_COUNT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  otb_pkg::cmd_t  cmd_i,
  otb_res_if.source      res_o
);

  localparam int unsigned SLOT_W    = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int unsigned IDX_EXT_W = (SLOT_W > otb_pkg::IDX_W) ? SLOT_W : otb_pkg::IDX_W;
  localparam int unsigned TW        = otb_pkg::TICK_W;
  localparam int unsigned LW        = otb_pkg::LEFT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_LAST,
    S_OUT
  } state_e;

  state_e                   state_q;
  logic [TW-1:0]            now_q;
  logic [TIMER_COUNT-1:0]   armed_q;
  logic [TIMER_COUNT-1:0]   wr_q;      // entry written since reset, else reads zero
  logic [SLOT_W-1:0]        cnt_q;
  logic                     cmp_vld_q;
  logic                     out_vld_q;

  logic [TW-1:0]            stamp_mem [TIMER_COUNT];
  logic [TW-1:0]            dl_mem    [TIMER_COUNT];

  otb_pkg::cmd_t            cur_q;
  logic                     wr_hit_q;
  logic [TW-1:0]            stamp_rd_q, dl_a_q, dl_b_q;
  logic [SLOT_W-1:0]        cmp_idx_q;
  logic [LW-1:0]            left_q;
  logic [TW-1:0]            running_q;
  logic                     el_q, fired_q;
  logic [TW-1:0]            best_q;
  logic [LW-1:0]            out_left_q;
  logic [TW-1:0]            out_running_q, out_next_q;
  logic                     out_el_q, out_fired_q;

  logic [IDX_EXT_W-1:0]     head_ext, cur_ext;
  logic [SLOT_W-1:0]        head_slot, cur_slot;
  logic                     pop, out_free, wr_en, disarm, fire, better;
  logic [TW-1:0]            stamp_v, dl_v, diff;
  logic [LW-1:0]            left_raw;
  logic                     el_raw;

  assign head_ext  = IDX_EXT_W'(cmd_i.idx);
  assign cur_ext   = IDX_EXT_W'(cur_q.idx);
  assign head_slot = head_ext[SLOT_W-1:0];
  assign cur_slot  = cur_ext[SLOT_W-1:0];

  assign cmd_ready_o = (state_q == S_IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign out_free    = !out_vld_q || res_o.ready;

  // per-request evaluation, all operands registered
  always_comb begin
    stamp_v  = wr_hit_q ? stamp_rd_q : '0;
    dl_v     = wr_hit_q ? dl_a_q : '0;
    // a start makes deadline - now equal to the duration itself
    diff     = (cur_q.op == otb_pkg::OP_START) ? cur_q.duration : dl_v - now_q;
    left_raw = diff[TW-1] ? '0 : diff[LW-1:0];
    el_raw   = (left_raw == '0);
    fire     = cur_q.hit && (cur_q.op == otb_pkg::OP_POLL) && el_raw && armed_q[cur_slot];
    wr_en    = (state_q == S_LOOK) && cur_q.hit && (cur_q.op == otb_pkg::OP_START);
    disarm   = cur_q.hit && ((cur_q.op == otb_pkg::OP_STOP) || fire);
    better   = cmp_vld_q && armed_q[cmp_idx_q] && (dl_b_q < best_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      now_q     <= '0;
      armed_q   <= '0;
      wr_q      <= '0;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (pop) begin
            if (cmd_i.op == otb_pkg::OP_TICK) begin
              now_q <= now_q + 1'b1;
            end
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (wr_en) begin
            armed_q[cur_slot] <= 1'b1;
            wr_q[cur_slot]    <= 1'b1;
          end else if (disarm) begin
            armed_q[cur_slot] <= 1'b0;
          end
          cnt_q     <= '0;
          cmp_vld_q <= 1'b0;
          state_q   <= S_SCAN;
        end
        S_SCAN: begin
          cmp_vld_q <= 1'b1;
          if (cnt_q == LAST_SLOT) begin
            state_q <= S_LAST;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_LAST: begin
          cmp_vld_q <= 1'b0;
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if ((state_q == S_OUT) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // timer memories: port A reads the addressed timer, port B walks the bank
  always_ff @(posedge clk_i) begin
    if (pop) begin
      stamp_rd_q <= stamp_mem[head_slot];
      dl_a_q     <= dl_mem[head_slot];
    end
    if (state_q == S_SCAN) begin
      dl_b_q <= dl_mem[cnt_q];
    end
    if (wr_en) begin
      stamp_mem[cur_slot] <= now_q;
      dl_mem[cur_slot]    <= now_q + cur_q.duration;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q    <= cmd_i;
      wr_hit_q <= wr_q[head_slot];
    end
    if (state_q == S_LOOK) begin
      left_q    <= cur_q.hit ? left_raw : '0;
      running_q <= (!cur_q.hit || (cur_q.op == otb_pkg::OP_START)) ? '0 : now_q - stamp_v;
      el_q      <= cur_q.hit && el_raw;
      fired_q   <= fire;
      best_q    <= '1;
    end else if (better) begin
      best_q <= dl_b_q;
    end
    if (state_q == S_SCAN) begin
      cmp_idx_q <= cnt_q;
    end
    if ((state_q == S_OUT) && out_free) begin
      out_left_q    <= left_q;
      out_running_q <= running_q;
      out_el_q      <= el_q;
      out_fired_q   <= fired_q;
      out_next_q    <= best_q;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.ticks_to_go   = out_left_q;
  assign res_o.time_running  = out_running_q;
  assign res_o.elapsed       = out_el_q;
  assign res_o.fired         = out_fired_q;
  assign res_o.next_deadline = out_next_q;

  a_armed_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armed_q & ~wr_q) == '0)
    else $error("armed timer without written deadline");

  a_look_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> $past(pop))
    else $error("update step without a popped command");

  a_fired_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_fired_q) |-> out_el_q)
    else $error("fired result that is not elapsed");

  a_now_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(now_q) |-> $past(pop && (cmd_i.op == otb_pkg::OP_TICK)))
    else $error("tick counter moved without a tick request");

endmodule

/* rtl/core/one_shot_timer_bank.sv */
// One-shot timer bank top level: front end, command queue, execution back end.
// The back end runs one command at a time and takes the next only after the result
//   is loaded, as it walks every timer's deadline once through a memory read port.
// Reset (async, active low): tick counter zero, all timers stopped, all stored
//   start stamps and deadlines read as zero until written. No clearing pass.
module one_shot_timer_bank #(
  parameter int unsigned TIMER_COUNT = otb_pkg::TIMER_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  otb_req_if.sink    req_i,
  otb_res_if.source  res_o
);

  // Front end -> queue
  logic           push_valid, push_ready;
  otb_pkg::cmd_t  push_cmd;

  // Queue -> back end
  logic           pop_valid, pop_ready;
  otb_pkg::cmd_t  pop_cmd;

  // Front end: checks the timer index against the bank size and packs the
  // request into a command. Requests are taken whenever the queue has room,
  // so a waiting result never blocks the input side by itself.
  otb_front #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // Two-entry command queue decouples request intake from execution.
  otb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // Back end sequence per command:
  //   pop    - tick bumps the counter, addressed timer read from memory
  //   update - start/stop/poll applied, time left / running computed
  //   walk   - TIMER_COUNT reads of the deadline memory plus one compare
  //            step, minimum kept over armed timers (all ones if none)
  //   output - result loaded into the output register once it is free
  otb_back #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .res_o       (res_o)
  );

endmodule

/* verif/otb_report_checker.sv */
`timescale 1ns / 1ps
// Report checker for the one-shot timer bank: watches the request and result channels,
// predicts every report from the accepted requests and compares it field by field.
// Depends on otb_pkg and the channel interfaces in otb_if.sv.
module otb_report_checker
  import otb_pkg::*;
#(
  parameter int unsigned TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  otb_req_if          req_i,
  otb_res_if          res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [LEFT_W-1:0] ticks_to_go;
    logic [TICK_W-1:0] time_running;
    logic              elapsed;
    logic              fired;
    logic [TICK_W-1:0] next_deadline;
  } report_t;

  // Shadow copy of the bank.
  logic [TICK_W-1:0]      now_q;
  logic [TICK_W-1:0]      stamp_q [TIMER_COUNT];
  logic [TICK_W-1:0]      due_q   [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] stopped_q;

  report_t     expected_reports [$];
  int unsigned mismatches;

  // Deadline minus now, taken as signed and clamped at zero.
  function automatic logic [LEFT_W-1:0] ticks_left(int unsigned slot);
    logic [TICK_W-1:0] gap;
    gap = due_q[slot] - now_q;
    return gap[TICK_W-1] ? '0 : gap[LEFT_W-1:0];
  endfunction

  function automatic logic [TICK_W-1:0] earliest_due();
    logic [TICK_W-1:0] best;
    best = '1;
    for (int unsigned k = 0; k < TIMER_COUNT; k++) begin
      if (!stopped_q[k] && due_q[k] < best) best = due_q[k];
    end
    return best;
  endfunction

  // Applies one request to the shadow bank and returns the report it causes.
  function automatic report_t apply_request(op_e op, logic [IDX_W-1:0] idx,
                                            logic [TICK_W-1:0] dur);
    report_t rep;
    logic    hit;
    rep = '0;
    hit = (idx < TIMER_COUNT);
    if (op == OP_TICK) begin
      now_q = now_q + 1'b1;
    end else if (hit) begin
      case (op)
        OP_START: begin
          stamp_q[idx]   = now_q;
          due_q[idx]     = now_q + dur;
          stopped_q[idx] = 1'b0;
        end
        OP_STOP: stopped_q[idx] = 1'b1;
        OP_POLL: begin
          // fires once per arming, then the timer is stopped
          if (!stopped_q[idx] && ticks_left(idx) == '0) begin
            rep.fired      = 1'b1;
            stopped_q[idx] = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (hit) begin
      rep.ticks_to_go  = ticks_left(idx);
      rep.time_running = now_q - stamp_q[idx];
      rep.elapsed      = (rep.ticks_to_go == '0);
    end
    rep.next_deadline = earliest_due();
    return rep;
  endfunction

  task automatic check_field(string name, logic [TICK_W-1:0] want, logic [TICK_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    if (!rst_ni) begin
      now_q     = '0;
      stopped_q = '1;
      for (int unsigned k = 0; k < TIMER_COUNT; k++) begin
        stamp_q[k] = '0;
        due_q[k]   = '0;
      end
      expected_reports.delete();
      mismatches = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        expected_reports.insert(expected_reports.size(),
                                apply_request(op_e'(req_i.opcode), req_i.slot_sel,
                                              req_i.duration));
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("ticks_to_go", want.ticks_to_go, res_i.ticks_to_go);
          check_field("time_running", want.time_running, res_i.time_running);
          check_field("elapsed", want.elapsed, res_i.elapsed);
          check_field("fired", want.fired, res_i.fired);
          check_field("next_deadline", want.next_deadline, res_i.next_deadline);
        end
      end
    end
    pending_o    <= expected_reports.size();
    fail_count_o <= mismatches;
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Top of the one-shot timer bank testbench: clock, reset, request stimulus, result
// back-pressure, watchdog and verdict. Depends on otb_pkg, otb_if.sv and the checker.
module tb;
  import otb_pkg::*;

  localparam int unsigned DRAIN_CYCLES   = TIMER_COUNT_DEF + 4; // settling wait before the verdict
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 400;

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct;   // chance per request that the sender holds off
  int unsigned recv_stall_pct;  // chance per cycle that the receiver is not ready
  int unsigned fail_count;
  int unsigned pending;         // reports still owed by the bank
  int unsigned quiet_cycles;

  otb_req_if req_if ();
  otb_res_if res_if ();

  one_shot_timer_bank u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // Watches both channels and keeps the shadow bank; only counts come back here.
  otb_report_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Watchdog: a long stretch with no request and no result accepted means a hang.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL one_shot_timer_bank");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request. An optional hold-off comes first, with valid low, so valid is never
  // lowered and raised in the same step. Returns at the edge that accepts the request.
  task automatic send_request(op_e op, logic [IDX_W-1:0] idx, logic [TICK_W-1:0] dur);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < send_idle_pct);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.slot_sel <= idx;
    req_if.duration <= dur;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Sender pauses until the bank has answered everything in flight.
  task automatic wait_for_reports();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mostly short countdowns so timers actually run out and fire under polling;
  // the rest are full-range, medium (17 to 80), sign-boundary and all-ones values.
  task automatic send_random_request();
    op_e               op;
    logic [TICK_W-1:0] dur;
    int unsigned       roll;
    roll = $urandom_range(99, 0);
    if (roll < 35)      op = OP_TICK;
    else if (roll < 55) op = OP_START;
    else if (roll < 65) op = OP_STOP;
    else                op = OP_POLL;
    roll = $urandom_range(99, 0);
    if (roll < 70) begin
      dur = $urandom_range(16, 0);
    end else if (roll < 85) begin
      dur = $urandom;
    end else begin
      case ($urandom_range(3, 0))
        0:       dur = 32'h7FFF_FFFF - $urandom_range(4, 0);
        1:       dur = 32'h8000_0000 + $urandom_range(4, 0);
        2:       dur = 32'hFFFF_FFFF - $urandom_range(4, 0);
        default: dur = $urandom_range(80, 17);
      endcase
    end
    send_request(op, IDX_W'($urandom), dur);
  endtask

  initial begin
    rst_ni          = 1'b0;
    send_idle_pct   = 6;
    recv_stall_pct  = 80;
    req_if.valid    = 1'b0;
    req_if.opcode   = OP_TICK;
    req_if.slot_sel = '0;
    req_if.duration = '0;
    res_if.ready    = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    send_request(OP_POLL, 3'd0, 32'h0);             // stopped timer straight out of reset
    send_request(OP_START, 3'd0, 32'h0);            // zero countdown: elapsed at once
    send_request(OP_POLL, 3'd0, 32'hFFFF_FFFF);     // fires and stops the timer
    send_request(OP_POLL, 3'd0, 32'h0);             // second poll must not fire
    send_request(OP_START, 3'd1, 32'hFFFF_FFFF);    // deadline all ones, looks like none armed
    send_request(OP_START, 3'd2, 32'h7FFF_FFFF);    // largest time left
    send_request(OP_START, 3'd3, 32'h8000_0000);    // negative distance clamps to zero
    send_request(OP_START, 3'd4, 32'h3);
    send_request(OP_TICK, 3'd7, 32'hFFFF_FFFF);
    send_request(OP_TICK, 3'd4, 32'h5555_5555);
    send_request(OP_TICK, 3'd2, 32'hAAAA_AAAA);
    send_request(OP_POLL, 3'd4, 32'h0);             // ran out while armed: fires
    send_request(OP_START, 3'd5, 32'h5);
    send_request(OP_START, 3'd5, 32'h2);            // restart of an armed timer
    send_request(OP_STOP, 3'd2, 32'h0);
    send_request(OP_POLL, 3'd2, 32'h0);             // stopped timer reports, no fire
    send_request(OP_POLL, 3'd1, 32'h0);
    send_request(OP_POLL, 3'd3, 32'h0);
    send_request(OP_STOP, 3'd7, 32'h0);             // never started
    send_request(OP_START, 3'd6, 32'hAAAA_AAAA);
    send_request(OP_TICK, 3'd5, 32'h0);
    send_request(OP_TICK, 3'd5, 32'h0);
    send_request(OP_POLL, 3'd5, 32'h0);
    send_request(OP_POLL, 3'd6, 32'h5555_5555);
    wait_for_reports();

    // Random part in three idling regimes, fully drained between them.
    repeat (PHASE_ITEMS) send_random_request();
    wait_for_reports();
    send_idle_pct  = 80;
    recv_stall_pct = 6;
    repeat (PHASE_ITEMS) send_random_request();
    wait_for_reports();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (PHASE_ITEMS) send_random_request();
    wait_for_reports();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS one_shot_timer_bank");
    end else begin
      $display("FAIL one_shot_timer_bank");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/otb_pkg.sv
rtl/core/otb_if.sv
rtl/core/otb_front.sv
rtl/core/otb_queue.sv
rtl/core/otb_back.sv
rtl/core/one_shot_timer_bank.sv
verif/otb_report_checker.sv
verif/tb.sv
